// ===== rtl/core/mrtu_pkg.sv =====
package mrtu_pkg;

	// Fixed frame geometry of a Modbus RTU request.
	localparam int FRAME_BYTES = 8;
	localparam int FB_W = $clog2(FRAME_BYTES);
	localparam int CRC_SPAN = 6;
	localparam int MAX_READ_REGS_DEF = 7;

	// Reply layout: positions of the fixed header bytes.
	localparam int POS_ADDR = 0;
	localparam int POS_FUNC = 1;
	localparam int POS_COUNT = 2;
	localparam int POS_ONE = 3;
	localparam int HDR_BYTES = 4;

	// Only this register is ever read back on the bus.
	localparam int REG_READ_INDEX = 1;

	localparam logic [4:0] COUNT_MAX = 5'd31;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [7:0] FUNC_READ = 8'h03;
	localparam logic [7:0] FUNC_WRITE = 8'h06;
	localparam logic [7:0] BROADCAST_ADDR = 8'hFF;
	localparam logic [7:0] BYTE_COUNT_ONE = 8'h01;

	typedef enum logic [1:0] {
		CMD_RX_BYTE = 2'd0,
		CMD_FRAME_END = 2'd1,
		CMD_LOCAL_WRITE = 2'd2
	} cmd_code_t;

	typedef struct packed {
		logic take;
		logic check_step;
		logic decide;
		logic emit;
	} ctl_cmd_t;

	typedef struct packed {
		logic item_frame_end;
		logic check_last;
		logic reply_go;
		logic out_free;
		logic emit_last;
	} dp_stat_t;

	// One byte of CRC-16/Modbus, reflected polynomial, LSB first.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
			input logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int b = 0; b < 8; b++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ===== rtl/core/mrtu_ctrl.sv =====
module mrtu_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  mrtu_pkg::dp_stat_t  stat,
	output mrtu_pkg::ctl_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DECIDE,
		ST_EMIT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid && stat.item_frame_end) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (stat.check_last) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					state_q <= stat.reply_go ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					if (stat.out_free && stat.emit_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		s_axis_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				cmd.take = s_axis_tvalid;
			end
			ST_CHECK: begin
				cmd.check_step = 1'b1;
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
			end
			ST_EMIT: begin
				cmd.emit = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ===== rtl/core/mrtu_dp.sv =====
module mrtu_dp #(
	parameter int MAX_READ_REGS = mrtu_pkg::MAX_READ_REGS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                slave_address_wr_en,
	input  logic [7:0]          slave_address_wr_data,
	input  logic [31:0]         s_axis_tdata,
	input  logic [1:0]          s_axis_tuser,
	input  logic                m_axis_tready,
	output logic                m_axis_tvalid,
	output logic [7:0]          m_axis_tdata,
	output logic                m_axis_tlast,
	input  mrtu_pkg::ctl_cmd_t  cmd,
	output mrtu_pkg::dp_stat_t  stat
);

	localparam int REPLY_MAX = 6 + 2 * MAX_READ_REGS;
	localparam int IW = $clog2(REPLY_MAX);
	localparam int NW = $clog2(MAX_READ_REGS + 1);

	logic [7:0]  rx_byte;
	logic [2:0]  reg_index;
	logic [15:0] reg_value;
	mrtu_pkg::cmd_code_t kind;

	logic [7:0]  frame_q [mrtu_pkg::FRAME_BYTES];
	logic [4:0]  count_q;
	logic        long_q;
	logic [7:0]  addr_q;
	logic [15:0] reg1_q;
	logic [15:0] crc_q;
	logic [2:0]  ptr_q;
	logic [NW-1:0] n_q;
	logic [IW-1:0] idx_q;
	logic        m_valid_q;
	logic [7:0]  m_data_q;
	logic        m_last_q;

	logic [15:0] field_a;
	logic [15:0] field_b;
	logic        frame_ok;
	logic [NW-1:0] n_sat;
	logic [IW-1:0] data_end;
	logic [7:0]  tx_byte;
	logic        emit_last;

	assign rx_byte = s_axis_tdata[7:0];
	assign reg_index = s_axis_tdata[10:8];
	assign reg_value = s_axis_tdata[26:11];
	assign kind = mrtu_pkg::cmd_code_t'(s_axis_tuser);

	assign field_a = {frame_q[2], frame_q[3]};
	assign field_b = {frame_q[4], frame_q[5]};

	assign frame_ok = long_q
		&& (frame_q[0] == addr_q || frame_q[0] == mrtu_pkg::BROADCAST_ADDR)
		&& (crc_q == {frame_q[7], frame_q[6]});

	assign n_sat = (field_b > 16'(MAX_READ_REGS)) ? NW'(MAX_READ_REGS) : field_b[NW-1:0];

	// Index of the CRC low byte; register data fills the span before it.
	assign data_end = IW'(mrtu_pkg::HDR_BYTES) + IW'({n_q, 1'b0});
	assign emit_last = (idx_q == data_end + IW'(1));

	always_comb begin
		if (idx_q == IW'(mrtu_pkg::POS_ADDR)) begin
			tx_byte = frame_q[0];
		end else if (idx_q == IW'(mrtu_pkg::POS_FUNC)) begin
			tx_byte = mrtu_pkg::FUNC_READ;
		end else if (idx_q == IW'(mrtu_pkg::POS_COUNT)) begin
			tx_byte = 8'({n_q, 1'b1});
		end else if (idx_q == IW'(mrtu_pkg::POS_ONE)) begin
			tx_byte = mrtu_pkg::BYTE_COUNT_ONE;
		end else if (idx_q < data_end) begin
			tx_byte = idx_q[0] ? reg1_q[7:0] : reg1_q[15:8];
		end else if (idx_q == data_end) begin
			tx_byte = crc_q[7:0];
		end else begin
			tx_byte = crc_q[15:8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			long_q <= 1'b0;
			addr_q <= 8'd1;
			reg1_q <= '0;
			ptr_q <= '0;
			idx_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (slave_address_wr_en) begin
				addr_q <= slave_address_wr_data;
			end
			if (cmd.take) begin
				case (kind)
					mrtu_pkg::CMD_RX_BYTE: begin
						if (count_q < mrtu_pkg::COUNT_MAX) begin
							count_q <= count_q + 5'd1;
						end
					end
					mrtu_pkg::CMD_FRAME_END: begin
						long_q <= (count_q >= 5'(mrtu_pkg::FRAME_BYTES));
						count_q <= '0;
						ptr_q <= '0;
					end
					mrtu_pkg::CMD_LOCAL_WRITE: begin
						if (reg_index == 3'(mrtu_pkg::REG_READ_INDEX)) begin
							reg1_q <= reg_value;
						end
					end
					default: begin
					end
				endcase
			end
			if (cmd.check_step) begin
				ptr_q <= ptr_q + 3'd1;
			end
			if (cmd.decide) begin
				idx_q <= '0;
				if (frame_ok && frame_q[1] == mrtu_pkg::FUNC_WRITE
						&& field_a == 16'(mrtu_pkg::REG_READ_INDEX)) begin
					reg1_q <= field_b;
				end
			end
			if (cmd.emit) begin
				idx_q <= idx_q + IW'(1);
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && kind == mrtu_pkg::CMD_RX_BYTE
				&& count_q < 5'(mrtu_pkg::FRAME_BYTES)) begin
			frame_q[count_q[mrtu_pkg::FB_W-1:0]] <= rx_byte;
		end
		if (cmd.take && kind == mrtu_pkg::CMD_FRAME_END) begin
			crc_q <= mrtu_pkg::CRC_INIT;
		end else if (cmd.check_step) begin
			crc_q <= mrtu_pkg::crc16_byte(crc_q, frame_q[ptr_q]);
		end else if (cmd.decide) begin
			crc_q <= mrtu_pkg::CRC_INIT;
		end else if (cmd.emit && idx_q < data_end) begin
			crc_q <= mrtu_pkg::crc16_byte(crc_q, tx_byte);
		end
		if (cmd.decide) begin
			n_q <= n_sat;
		end
		if (cmd.emit) begin
			m_data_q <= tx_byte;
			m_last_q <= emit_last;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = m_data_q;
	assign m_axis_tlast = m_last_q;

	assign stat.item_frame_end = (kind == mrtu_pkg::CMD_FRAME_END);
	assign stat.check_last = (ptr_q == 3'(mrtu_pkg::CRC_SPAN - 1));
	assign stat.reply_go = frame_ok && frame_q[1] == mrtu_pkg::FUNC_READ
		&& frame_q[0] != mrtu_pkg::BROADCAST_ADDR;
	assign stat.out_free = !m_valid_q || m_axis_tready;
	assign stat.emit_last = emit_last;

endmodule

// ===== rtl/core/modbus_rtu_slave_frame_handler_top.sv =====
// A received byte or a local register update is absorbed as soon as it is accepted.
// A frame end runs the CRC check over bytes 0 to 5 and then an accept decision; a read reply
// streams out at one byte per cycle while m_axis_tready is high, 6 + 2*n bytes with n up to MAX_READ_REGS.
// Throughput is set by the byte-wide CRC unit shared by the check and the reply.
// Reset (arst_n low, asynchronous) clears the byte count, register 1, the output
// valid and restores the slave address to 1; the frame buffer is not cleared.
module modbus_rtu_slave_frame_handler_top #(
	parameter int MAX_READ_REGS = mrtu_pkg::MAX_READ_REGS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration: the slave address register, written when the enable is high.
	input  logic        slave_address_wr_en,
	input  logic [7:0]  slave_address_wr_data,
	// Input items.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// Fields from bit 0 up: rx_byte [7:0], reg_index [10:8], reg_value [26:11], zero fill.
	input  logic [31:0] s_axis_tdata,
	// Fields from bit 0 up: cmd [1:0] (received byte, frame end, local update).
	input  logic [1:0]  s_axis_tuser,
	// Result items, one per reply byte.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// Fields from bit 0 up: tx_byte [7:0].
	output logic [7:0]  m_axis_tdata,
	// Marks the CRC high byte, the last item of a reply.
	output logic        m_axis_tlast
);

	// The controller sequences the frame-end work: it holds off new items while
	// the CRC over bytes 0 to 5 runs, makes the accept decision and then paces
	// the reply into the output register.
	mrtu_pkg::ctl_cmd_t cmd_w;
	mrtu_pkg::dp_stat_t stat_w;

	mrtu_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.stat          (stat_w),
		.cmd           (cmd_w)
	);

	// The datapath holds the frame buffer, byte count, slave address, the
	// readable register, the CRC unit and the output register.
	mrtu_dp #(
		.MAX_READ_REGS (MAX_READ_REGS)
	) u_dp (
		.clk                   (clk),
		.arst_n                (arst_n),
		.slave_address_wr_en   (slave_address_wr_en),
		.slave_address_wr_data (slave_address_wr_data),
		.s_axis_tdata          (s_axis_tdata),
		.s_axis_tuser          (s_axis_tuser),
		.m_axis_tready         (m_axis_tready),
		.m_axis_tvalid         (m_axis_tvalid),
		.m_axis_tdata          (m_axis_tdata),
		.m_axis_tlast          (m_axis_tlast),
		.cmd                   (cmd_w),
		.stat                  (stat_w)
	);

	// A reply byte is only ever loaded into a free output register.
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_w.emit |-> stat_w.out_free)
		else $error("reply byte loaded into an occupied output register");

	// No item is taken while the CRC check runs.
	a_check_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_w.check_step |=> !s_axis_tready)
		else $error("input accepted during the frame check");

	// After the last reply byte the block accepts items again.
	a_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_w.emit && stat_w.emit_last |=> s_axis_tready)
		else $error("block did not return to accepting items after a reply");

	// A frame end with no reply goes straight back to accepting items.
	a_no_reply: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_w.decide && !stat_w.reply_go |=> s_axis_tready && !cmd_w.emit)
		else $error("rejected frame did not return to idle");

endmodule
